/* design/dhs_pkg.sv */
// package: shared types and constants for the disk head scheduler
`timescale 1ns / 1ps
`default_nettype none
package dhs_pkg;
   localparam int CYL_W  = 16;
   localparam int MOV_W  = 24;
   localparam int STEP_W = 6;
   localparam int MODE_W = 3;
   localparam int IDX_W  = 2;

   localparam logic [MODE_W-1:0] MODE_FCFS  = 3'd0;
   localparam logic [MODE_W-1:0] MODE_SSTF  = 3'd1;
   localparam logic [MODE_W-1:0] MODE_SCAN  = 3'd2;
   localparam logic [MODE_W-1:0] MODE_CSCAN = 3'd3;
   localparam logic [MODE_W-1:0] MODE_LOOK  = 3'd4;
   localparam logic [MODE_W-1:0] MODE_CLOOK = 3'd5;

   localparam logic [IDX_W-1:0] REG_POLICY = 2'd0;
   localparam logic [IDX_W-1:0] REG_START  = 2'd1;
   localparam logic [IDX_W-1:0] REG_LAST   = 2'd2;

   // selection rule for one search pass over the queue
   localparam logic [2:0] SEL_INDEX   = 3'd0; // entry at cursor index
   localparam logic [2:0] SEL_NEAREST = 3'd1; // nearest unserved to head
   localparam logic [2:0] SEL_UP      = 3'd2; // smallest unserved at or above key
   localparam logic [2:0] SEL_DOWN    = 3'd3; // largest unserved below key
   localparam logic [2:0] SEL_MIN     = 3'd4; // smallest unserved

   // controller to datapath commands
   typedef struct packed {
      logic             batch_init;  // head <- start, sum <- 0, clear flags
      logic             scan_start;  // begin a search pass
      logic [2:0]       sel;         // rule of the pass
      logic             visit_found; // move head to the found entry
      logic             visit_end;   // move head to last cylinder
      logic             visit_zero;  // jump to cylinder 0 adding last cylinder
      logic             clear_q;     // empty the queue
   } cmd_type;

   // datapath to controller status
   typedef struct packed {
      logic scan_busy;
      logic found;
      logic head_below_last;
   } sts_type;
endpackage
`default_nettype wire

/* design/disk_head_scheduler.sv */
// top level: disk head scheduler with stream ports and register writes
`timescale 1ns / 1ps
`default_nettype none
// Requests are stored one per cycle while the block is idle; the item marked
// last starts scheduling, during which req_tready is low. Each visit needs one
// search pass over the stored queue of n entries: a start state, a read and
// compare of every entry, and an emit state that waits until the result side
// is free. A batch of n requests takes n such passes, plus one or two passes
// that find nothing, a visit per sweep end or return where the policy has one,
// and a final state that empties the queue. One visit is held back until the
// next one is known; the last visit is flagged with tlast and moves to the
// result register as the queue is emptied.
module disk_head_scheduler #(
   parameter int QUEUE_DEPTH = 32
) (
   input  wire logic        clock,
   input  wire logic        reset,
   input  wire logic        req_tvalid,
   output logic             req_tready,
   input  wire logic [15:0] req_tdata,   // request_cylinder[15:0]
   input  wire logic        req_tlast,   // is_last_request
   output logic             rsp_tvalid,
   input  wire logic        rsp_tready,
   output logic [47:0]      rsp_tdata,   // step_number[5:0], visit_cylinder[21:6],
                                         // movement_total[45:22], zero pad
   output logic             rsp_tlast,   // is_last_step
   input  wire logic        csr_wen,
   input  wire logic [1:0]  csr_index,
   input  wire logic [15:0] csr_wdata
);
   import dhs_pkg::*;

   logic [MODE_W-1:0] mode_ff;
   logic [CYL_W-1:0]  start_ff, last_ff;
   cmd_type           cmd;
   sts_type           sts;
   logic              emit, busy, accept, out_free;
   logic [CYL_W-1:0]  head_next, sat_cyl;
   logic [MOV_W-1:0]  moved_next;
   logic [$clog2(QUEUE_DEPTH+1)-1:0] count;
   // one visit held back so tlast can be set once the batch is known to end
   logic              hold_ff;
   logic [STEP_W-1:0] step_ff, hstep_ff;
   logic [CYL_W-1:0]  hcyl_ff;
   logic [MOV_W-1:0]  hmov_ff;
   logic              ov_ff;
   logic [STEP_W-1:0] ostep_ff;
   logic [CYL_W-1:0]  ocyl_ff;
   logic [MOV_W-1:0]  omov_ff;
   logic              olast_ff;
   logic              flush, move;

   assign req_tready = !busy;
   assign accept     = req_tvalid && req_tready;
   assign sat_cyl    = (req_tdata > last_ff) ? last_ff : req_tdata;

   // configuration registers
   always_ff @(posedge clock) begin
      if (reset) begin
         mode_ff  <= MODE_FCFS;
         start_ff <= '0;
         last_ff  <= 16'd199;
      end else if (csr_wen) begin
         case (csr_index)
            REG_POLICY: mode_ff  <= csr_wdata[MODE_W-1:0];
            REG_START:  start_ff <= csr_wdata;
            REG_LAST:   last_ff  <= csr_wdata;
            default:    ;
         endcase
      end
   end

   dhs_datapath #(.QUEUE_DEPTH(QUEUE_DEPTH)) u_dp (
      .clock(clock), .reset(reset), .push(accept), .push_cyl(sat_cyl),
      .start_cyl(start_ff), .last_cyl(last_ff), .cmd(cmd), .sts(sts),
      .head_next(head_next), .moved_next(moved_next), .count(count)
   );

   dhs_control u_ctl (
      .clock(clock), .reset(reset), .start(accept && req_tlast),
      .mode(mode_ff), .sts(sts), .out_free(out_free), .cmd(cmd),
      .emit(emit), .busy(busy)
   );

   // hold stage moves to output when output free and a newer visit or end
   assign flush    = cmd.clear_q;
   assign out_free = !hold_ff || !ov_ff || rsp_tready;
   assign move     = hold_ff && (emit || flush) && (!ov_ff || rsp_tready);

   always_ff @(posedge clock) begin
      if (reset) begin
         hold_ff   <= 1'b0;
         ov_ff     <= 1'b0;
         step_ff   <= '0;
      end else begin
         if (move) begin
            ov_ff    <= 1'b1;
            ostep_ff <= hstep_ff;
            ocyl_ff  <= hcyl_ff;
            omov_ff  <= hmov_ff;
            olast_ff <= flush;
         end else if (ov_ff && rsp_tready) begin
            ov_ff <= 1'b0;
         end
         if (emit) begin
            hold_ff  <= 1'b1;
            hstep_ff <= step_ff + 1'b1;
            hcyl_ff  <= head_next;
            hmov_ff  <= moved_next;
         end else if (move) begin
            hold_ff  <= 1'b0;
         end
         if (accept && req_tlast) begin
            step_ff <= '0;
         end else if (emit) begin
            step_ff <= step_ff + 1'b1;
         end
      end
   end

   assign rsp_tvalid = ov_ff;
   assign rsp_tdata  = {2'b00, omov_ff, ocyl_ff, ostep_ff};
   assign rsp_tlast  = olast_ff;

`ifndef ASSERT_OFF
   // no item taken while a batch is scheduled
   a_no_accept_busy: assert property (@(posedge clock) disable iff (reset)
      busy |-> !req_tready) else $error("accept while busy");
   // queue never exceeds its depth
   a_count: assert property (@(posedge clock) disable iff (reset)
      count <= ($clog2(QUEUE_DEPTH+1))'(QUEUE_DEPTH)) else $error("queue overflow");
   // emit only when output path free
   a_emit: assert property (@(posedge clock) disable iff (reset)
      emit |-> out_free) else $error("emit blocked");
`endif
endmodule
`default_nettype wire

/* design/dhs_ram.sv */
// generic single-port write, single-port registered read memory
`timescale 1ns / 1ps
`default_nettype none
module dhs_ram #(
   parameter int WIDTH = 16,
   parameter int DEPTH = 32
) (
   input  wire logic                                       clock,
   input  wire logic                                       wr_en,
   input  wire logic [(DEPTH > 1 ? $clog2(DEPTH) : 1)-1:0] wr_addr,
   input  wire logic [WIDTH-1:0]                           wr_data,
   input  wire logic [(DEPTH > 1 ? $clog2(DEPTH) : 1)-1:0] rd_addr,
   output logic      [WIDTH-1:0]                           rd_data
);
   logic [WIDTH-1:0] mem_ff [DEPTH];

   // write and registered read
   always_ff @(posedge clock) begin
      if (wr_en) begin
         mem_ff[wr_addr] <= wr_data;
      end
      rd_data <= mem_ff[rd_addr];
   end
endmodule
`default_nettype wire

/* design/dhs_datapath.sv */
// datapath: request store, served flags, search pass, head and movement
`timescale 1ns / 1ps
`default_nettype none
module dhs_datapath #(
   parameter int QUEUE_DEPTH = 32
) (
   input  wire logic                        clock,
   input  wire logic                        reset,
   input  wire logic                        push,
   input  wire logic [dhs_pkg::CYL_W-1:0]   push_cyl,
   input  wire logic [dhs_pkg::CYL_W-1:0]   start_cyl,
   input  wire logic [dhs_pkg::CYL_W-1:0]   last_cyl,
   input  wire dhs_pkg::cmd_type            cmd,
   output dhs_pkg::sts_type                 sts,
   output logic      [dhs_pkg::CYL_W-1:0]   head_next,
   output logic      [dhs_pkg::MOV_W-1:0]   moved_next,
   output logic      [$clog2(QUEUE_DEPTH+1)-1:0] count
);
   import dhs_pkg::*;
   localparam int AW = (QUEUE_DEPTH > 1) ? $clog2(QUEUE_DEPTH) : 1;
   localparam int CW = $clog2(QUEUE_DEPTH+1);

   logic [CW-1:0]    count_ff, count_in;
   logic [QUEUE_DEPTH-1:0] served_ff, served_in;
   logic [CYL_W-1:0] head_ff, head_in;
   logic [MOV_W-1:0] moved_ff, moved_in;
   // search pass
   logic             busy_ff, busy_in;
   logic             rdv_ff, rdv_in;      // read data valid next cycle
   logic [CW-1:0]    ptr_ff, ptr_in;      // next address to read
   logic [AW-1:0]    ridx_ff, ridx_in;    // address of data on ram output
   logic [2:0]       sel_ff, sel_in;
   logic [CYL_W-1:0] key_ff, key_in;
   logic             fnd_ff, fnd_in;
   logic [AW-1:0]    bidx_ff, bidx_in;
   logic [CYL_W-1:0] bval_ff, bval_in;
   logic [CYL_W-1:0] bdist_ff, bdist_in;
   logic [CYL_W-1:0] rd_data;
   logic [AW-1:0]    wr_addr, rd_addr;
   logic [CYL_W-1:0] gap_d, jump;
   logic             better, cand;
   // fcfs walks the store in order; its index is the count of visits so far
   logic [CW-1:0]    moved_idx_key;

   assign wr_addr = count_ff[AW-1:0];
   assign rd_addr = ptr_ff[AW-1:0];
   assign moved_idx_key = CW'($countones(served_ff));

   dhs_ram #(.WIDTH(CYL_W), .DEPTH(QUEUE_DEPTH)) u_store (
      .clock   (clock),
      .wr_en   (push && (count_ff < CW'(QUEUE_DEPTH))),
      .wr_addr (wr_addr),
      .wr_data (push_cyl),
      .rd_addr (rd_addr),
      .rd_data (rd_data)
   );

   // distance of the entry on the ram output from the head
   assign gap_d = (rd_data > head_ff) ? rd_data - head_ff : head_ff - rd_data;

   // compare one entry against the running best
   always_comb begin
      cand   = !served_ff[ridx_ff];
      better = 1'b0;
      case (sel_ff)
         SEL_INDEX:   better = 1'b1;
         SEL_NEAREST: better = !fnd_ff || (gap_d < bdist_ff);
         SEL_UP:      better = (rd_data >= key_ff) && (!fnd_ff || rd_data < bval_ff);
         SEL_DOWN:    better = (rd_data < key_ff) && (!fnd_ff || rd_data > bval_ff);
         SEL_MIN:     better = !fnd_ff || (rd_data < bval_ff);
         default:     better = 1'b0;
      endcase
      if (sel_ff == SEL_INDEX) begin
         cand = cand && (ridx_ff == AW'(key_ff));
      end
   end

   assign jump = (bval_ff > head_ff) ? bval_ff - head_ff : head_ff - bval_ff;

   // next state of the datapath
   always_comb begin
      count_in  = count_ff;
      served_in = served_ff;
      head_in   = head_ff;
      moved_in  = moved_ff;
      busy_in   = busy_ff;
      rdv_in    = 1'b0;
      ptr_in    = ptr_ff;
      ridx_in   = rd_addr;
      sel_in    = sel_ff;
      key_in    = key_ff;
      fnd_in    = fnd_ff;
      bidx_in   = bidx_ff;
      bval_in   = bval_ff;
      bdist_in  = bdist_ff;
      if (push && count_ff < CW'(QUEUE_DEPTH)) begin
         count_in = count_ff + 1'b1;
      end
      if (busy_ff) begin
         if (ptr_ff < count_ff) begin
            rdv_in = 1'b1;
            ptr_in = ptr_ff + 1'b1;
         end else if (!rdv_ff) begin
            busy_in = 1'b0;
         end
      end
      if (rdv_ff && cand && better) begin
         fnd_in   = 1'b1;
         bidx_in  = ridx_ff;
         bval_in  = rd_data;
         bdist_in = gap_d;
      end
      if (cmd.scan_start) begin
         busy_in = 1'b1;
         ptr_in  = '0;
         sel_in  = cmd.sel;
         fnd_in  = 1'b0;
         // index pass uses the step as key; others use the head or start
         key_in  = (cmd.sel == SEL_INDEX) ? CYL_W'(moved_idx_key) :
                   (cmd.sel == SEL_DOWN) ? start_cyl : head_ff;
         if (cmd.sel == SEL_UP) begin
            key_in = head_ff;
         end
      end
      if (cmd.visit_found) begin
         served_in[bidx_ff] = 1'b1;
         head_in  = bval_ff;
         moved_in = moved_ff + MOV_W'(jump);
      end
      if (cmd.visit_end) begin
         head_in  = last_cyl;
         moved_in = moved_ff + MOV_W'(last_cyl - head_ff);
      end
      if (cmd.visit_zero) begin
         head_in  = '0;
         moved_in = moved_ff + MOV_W'(last_cyl);
      end
      if (cmd.batch_init) begin
         head_in   = start_cyl;
         moved_in  = '0;
         served_in = '0;
      end
      if (cmd.clear_q) begin
         count_in  = '0;
         served_in = '0;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         count_ff  <= '0;
         served_ff <= '0;
         head_ff   <= '0;
         moved_ff  <= '0;
         busy_ff   <= 1'b0;
         rdv_ff    <= 1'b0;
         fnd_ff    <= 1'b0;
      end else begin
         count_ff  <= count_in;
         served_ff <= served_in;
         head_ff   <= head_in;
         moved_ff  <= moved_in;
         busy_ff   <= busy_in;
         rdv_ff    <= rdv_in;
         fnd_ff    <= fnd_in;
      end
      ptr_ff   <= ptr_in;
      ridx_ff  <= ridx_in;
      sel_ff   <= sel_in;
      key_ff   <= key_in;
      bidx_ff  <= bidx_in;
      bval_ff  <= bval_in;
      bdist_ff <= bdist_in;
   end

   assign sts.scan_busy       = busy_ff || cmd.scan_start;
   assign sts.found           = fnd_ff;
   assign sts.head_below_last = head_ff < last_cyl;
   // head and movement after the visit commanded this cycle
   assign head_next  = head_in;
   assign moved_next = moved_in;
   assign count = count_ff;
endmodule
`default_nettype wire

/* design/dhs_control.sv */
// controller: policy sequencing over search passes and result handshake
`timescale 1ns / 1ps
`default_nettype none
module dhs_control (
   input  wire logic                      clock,
   input  wire logic                      reset,
   input  wire logic                      start,
   input  wire logic [dhs_pkg::MODE_W-1:0] mode,
   input  wire dhs_pkg::sts_type          sts,
   input  wire logic                      out_free,
   output dhs_pkg::cmd_type               cmd,
   output logic                           emit,
   output logic                           busy
);
   import dhs_pkg::*;

   localparam logic [2:0] ST_IDLE  = 3'd0;
   localparam logic [2:0] ST_SCAN  = 3'd1;
   localparam logic [2:0] ST_WAIT  = 3'd2;
   localparam logic [2:0] ST_EMIT  = 3'd3;
   localparam logic [2:0] ST_END   = 3'd4;
   localparam logic [2:0] ST_ZERO  = 3'd5;
   localparam logic [2:0] ST_CLEAR = 3'd6;

   // phase of the sweep: 0 first part, 1 second part
   logic [2:0] state_ff, state_in;
   logic       phase_ff, phase_in;
   logic [2:0] sel;

   // rule for the current pass
   always_comb begin
      case (mode)
         MODE_SSTF:  sel = SEL_NEAREST;
         MODE_SCAN, MODE_LOOK: sel = phase_ff ? SEL_DOWN : SEL_UP;
         MODE_CSCAN, MODE_CLOOK: sel = phase_ff ? SEL_MIN : SEL_UP;
         default:    sel = SEL_INDEX;
      endcase
   end

   always_comb begin
      state_in = state_ff;
      phase_in = phase_ff;
      cmd      = '0;
      cmd.sel  = sel;
      emit     = 1'b0;
      case (state_ff)
         ST_IDLE: begin
            if (start) begin
               cmd.batch_init = 1'b1;
               phase_in = 1'b0;
               state_in = ST_SCAN;
            end
         end
         ST_SCAN: begin
            cmd.scan_start = 1'b1;
            state_in = ST_WAIT;
         end
         ST_WAIT: begin
            if (!sts.scan_busy) begin
               if (sts.found) begin
                  state_in = ST_EMIT;
               end else if (!phase_ff && (mode == MODE_SCAN || mode == MODE_CSCAN)) begin
                  state_in = sts.head_below_last ? ST_END :
                             (mode == MODE_CSCAN ? ST_ZERO : ST_SCAN);
                  phase_in = 1'b1;
               end else if (!phase_ff && (mode == MODE_LOOK || mode == MODE_CLOOK)) begin
                  phase_in = 1'b1;
                  state_in = ST_SCAN;
               end else begin
                  state_in = ST_CLEAR;
               end
            end
         end
         ST_EMIT: begin
            if (out_free) begin
               cmd.visit_found = 1'b1;
               emit = 1'b1;
               state_in = ST_SCAN;
            end
         end
         ST_END: begin
            if (out_free) begin
               cmd.visit_end = 1'b1;
               emit = 1'b1;
               state_in = (mode == MODE_CSCAN) ? ST_ZERO : ST_SCAN;
            end
         end
         ST_ZERO: begin
            if (out_free) begin
               cmd.visit_zero = 1'b1;
               emit = 1'b1;
               state_in = ST_SCAN;
            end
         end
         // empty the queue once the held last visit can move out
         ST_CLEAR: begin
            if (out_free) begin
               cmd.clear_q = 1'b1;
               state_in = ST_IDLE;
            end
         end
         default: state_in = ST_IDLE;
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff <= ST_IDLE;
         phase_ff <= 1'b0;
      end else begin
         state_ff <= state_in;
         phase_ff <= phase_in;
      end
   end

   assign busy = (state_ff != ST_IDLE);
endmodule
`default_nettype wire
